// ----- rtl/arpc_pkg.sv -----
// arpc_pkg: types, codes and defaults shared by the ARP cache modules.
// No dependencies.

package arpc_pkg;

    localparam int CACHE_DEPTH_DEF = 32;
    localparam int REQ_DEPTH_DEF   = 16;
    localparam int MAX_OUT         = 16;
    localparam int NEMIT_W         = $clog2(MAX_OUT + 1);

    localparam logic [16:0] AGE_MAX = 17'h1FFFF;
    localparam logic [15:0] TIMEOUT_RST   = 16'd30;
    localparam logic [7:0]  MAX_SENDS_RST = 8'd5;

    // request codes
    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_QUEUE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // result kinds
    localparam logic [1:0] K_LOOKUP = 2'd0;
    localparam logic [1:0] K_SLOT   = 2'd1;
    localparam logic [1:0] K_SEND   = 2'd2;
    localparam logic [1:0] K_DONE   = 2'd3;

    // configuration register indexes
    localparam logic REG_TIMEOUT   = 1'b0;
    localparam logic REG_MAX_SENDS = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] ip_addr;
        logic [47:0] mac_addr;
        logic [3:0]  iface_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic [47:0] mac_out;
        logic [3:0]  slot;
        logic        table_full;
        logic [31:0] target_ip;
        logic [3:0]  out_iface;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [16:0] age;
    } t_centry;

    typedef struct packed {
        logic [31:0] ip;
        logic [3:0]  iface;
        logic [7:0]  sends;
    } t_pentry;

    typedef enum logic [2:0] {
        S_IDLE, S_CSCAN, S_CDRAIN, S_CWRITE, S_PSCAN, S_PDRAIN, S_PWRITE, S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // latch the request
        logic c_rd;   // read cache entry at c_addr
        logic p_rd;   // read request entry at p_addr
        logic c_wr;   // insert write into cache
        logic p_wr;   // queue write into request table
        logic fin;    // produce final result
    } t_cmd;

endpackage

// ----- rtl/arpc_ctrl.sv -----
// arpc_ctrl: sequencer that walks the cache and request tables.
// Depends on arpc_pkg.

module arpc_ctrl import arpc_pkg::*; #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
    parameter int REQ_DEPTH   = REQ_DEPTH_DEF,
    localparam int CW = $clog2(CACHE_DEPTH),
    localparam int PW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_op,
    output logic          o_busy,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_caddr,
    output logic [PW-1:0] o_paddr
);

    t_state r_state, n_state;
    logic [2:0]    r_op;
    logic [CW-1:0] r_cidx;
    logic [PW-1:0] r_pidx;
    logic          c_last, p_last;

    assign c_last = (r_cidx == CW'(CACHE_DEPTH - 1));
    assign p_last = (r_pidx == PW'(REQ_DEPTH - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_LOOKUP || i_op == OP_INSERT || i_op == OP_TICK)
                        n_state = S_CSCAN;
                    else if (i_op == OP_QUEUE || i_op == OP_REMOVE)
                        n_state = S_PSCAN;
                    else
                        n_state = S_DONE;
                end
            end
            S_CSCAN:  if (c_last) n_state = S_CDRAIN;
            S_CDRAIN: begin
                if (r_op == OP_INSERT)    n_state = S_CWRITE;
                else if (r_op == OP_TICK) n_state = S_PSCAN;
                else                      n_state = S_DONE;
            end
            S_CWRITE: n_state = S_PSCAN;
            S_PSCAN:  if (p_last) n_state = S_PDRAIN;
            S_PDRAIN: n_state = (r_op == OP_QUEUE) ? S_PWRITE : S_DONE;
            S_PWRITE: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && i_start;
        o_cmd.c_rd = (r_state == S_CSCAN);
        o_cmd.p_rd = (r_state == S_PSCAN);
        o_cmd.c_wr = (r_state == S_CWRITE);
        o_cmd.p_wr = (r_state == S_PWRITE);
        o_cmd.fin  = (r_state == S_DONE);
        o_busy     = (r_state != S_IDLE);
        o_caddr    = r_cidx;
        o_paddr    = r_pidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_LOOKUP;
            r_cidx  <= '0;
            r_pidx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_start) r_op <= i_op;
            r_cidx <= (r_state == S_CSCAN) ? r_cidx + 1'b1 : '0;
            r_pidx <= (r_state == S_PSCAN) ? r_pidx + 1'b1 : '0;
        end
    end

endmodule

// ----- rtl/arpc_dp.sv -----
// arpc_dp: cache and request tables, scan trackers and result register.
// Depends on arpc_pkg.

module arpc_dp import arpc_pkg::*; #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
    parameter int REQ_DEPTH   = REQ_DEPTH_DEF,
    localparam int CW = $clog2(CACHE_DEPTH),
    localparam int PW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [CW-1:0] i_caddr,
    input  logic [PW-1:0] i_paddr,
    input  t_req          i_req,
    input  logic [15:0]   i_timeout,
    input  logic [7:0]    i_max_sends,
    output logic          o_valid,
    output t_res          o_res
);

    // tables
    t_centry cmem [CACHE_DEPTH];
    t_pentry pmem [REQ_DEPTH];
    logic [CACHE_DEPTH-1:0] r_cval;
    logic [REQ_DEPTH-1:0]   r_pval;
    t_centry r_crd;
    t_pentry r_prd;

    t_req r_req;

    // scan stage
    logic          r_cs_v, r_ps_v;
    logic [CW-1:0] r_cs_idx;
    logic [PW-1:0] r_ps_idx;

    // trackers
    logic          r_hit;
    logic [47:0]   r_mac;
    logic          r_mfound, r_ffound;
    logic [CW-1:0] r_midx, r_fidx, r_oidx;
    logic [16:0]   r_oage;
    logic          r_pfound, r_pffound;
    logic [PW-1:0] r_pidx, r_pfidx;
    logic [NEMIT_W-1:0] r_nemit;
    logic          r_held_v;
    t_res          r_held;

    t_res r_out;
    logic r_out_v;

    // stage decode
    logic        cv, pv, c_match, p_match;
    logic [16:0] age_n;
    logic        age_exp;
    logic        emit, drop;
    logic [CW-1:0] ins_tgt;
    logic [PW+3:0] ps_ext, pidx_ext, pfidx_ext;
    t_res        send_res, fin_res;

    assign cv      = r_cval[r_cs_idx];
    assign pv      = r_pval[r_ps_idx];
    assign c_match = cv && (r_crd.ip == r_req.ip_addr);
    assign p_match = pv && (r_prd.ip == r_req.ip_addr);
    assign age_n   = (r_crd.age == AGE_MAX) ? r_crd.age : r_crd.age + 17'd1;
    assign age_exp = age_n > {1'b0, i_timeout};
    assign emit = r_ps_v && (r_req.req_type == OP_TICK) && pv &&
                  (r_nemit < NEMIT_W'(MAX_OUT)) && (r_prd.sends < i_max_sends);
    assign drop = r_ps_v && (r_req.req_type == OP_TICK) && pv &&
                  (r_nemit < NEMIT_W'(MAX_OUT)) && !(r_prd.sends < i_max_sends);
    assign ins_tgt = r_mfound ? r_midx : (r_ffound ? r_fidx : r_oidx);

    // slot field keeps the low four bits of an index
    assign ps_ext    = {4'b0, r_ps_idx};
    assign pidx_ext  = {4'b0, r_pidx};
    assign pfidx_ext = {4'b0, r_pfidx};

    always_comb begin
        send_res           = '0;
        send_res.kind      = K_SEND;
        send_res.slot      = ps_ext[3:0];
        send_res.target_ip = r_prd.ip;
        send_res.out_iface = r_prd.iface;
    end

    always_comb begin
        fin_res      = '0;
        fin_res.kind = K_DONE;
        fin_res.last = 1'b1;
        unique case (r_req.req_type)
            OP_LOOKUP: begin
                fin_res.kind    = K_LOOKUP;
                fin_res.hit     = r_hit;
                fin_res.mac_out = r_mac;
            end
            OP_INSERT: begin
                fin_res.kind = K_SLOT;
                fin_res.hit  = r_pfound;
                fin_res.slot = r_pfound ? pidx_ext[3:0] : 4'd0;
            end
            OP_QUEUE: begin
                fin_res.kind       = K_SLOT;
                fin_res.slot       = r_pfound ? pidx_ext[3:0] :
                                     (r_pffound ? pfidx_ext[3:0] : 4'd0);
                fin_res.table_full = !r_pfound && !r_pffound;
            end
            OP_REMOVE: begin
                fin_res.slot = r_pfound ? pidx_ext[3:0] : 4'd0;
            end
            OP_TICK: begin
                if (r_held_v) begin
                    fin_res      = r_held;
                    fin_res.last = 1'b1;
                end
            end
            default: fin_res.kind = K_DONE;
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.c_rd) r_crd <= cmem[i_caddr];
        if (r_cs_v && r_req.req_type == OP_TICK && cv)
            cmem[r_cs_idx] <= '{ip: r_crd.ip, mac: r_crd.mac, age: age_n};
        else if (i_cmd.c_wr)
            cmem[ins_tgt] <= '{ip: r_req.ip_addr, mac: r_req.mac_addr, age: 17'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.p_rd) r_prd <= pmem[i_paddr];
        if (emit)
            pmem[r_ps_idx] <= '{ip: r_prd.ip, iface: r_prd.iface,
                                sends: r_prd.sends + 8'd1};
        else if (i_cmd.p_wr && !r_pfound && r_pffound)
            pmem[r_pfidx] <= '{ip: r_req.ip_addr, iface: r_req.iface_id, sends: 8'd0};
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        r_cs_idx <= i_caddr;
        r_ps_idx <= i_paddr;
        if (i_cmd.load) begin
            r_mac  <= '0;
            r_oage <= '0;
            r_midx <= '0;
            r_fidx <= '0;
            r_oidx <= '0;
            r_pidx <= '0;
            r_pfidx <= '0;
        end
        if (r_cs_v) begin
            if (!r_hit && c_match) r_mac <= r_crd.mac;
            if (!r_mfound && c_match) r_midx <= r_cs_idx;
            if (!r_ffound && !cv) r_fidx <= r_cs_idx;
            if (r_cs_idx == '0 || r_crd.age > r_oage) begin
                r_oidx <= r_cs_idx;
                r_oage <= r_crd.age;
            end
        end
        if (r_ps_v) begin
            if (!r_pfound && p_match) r_pidx <= r_ps_idx;
            if (!r_pffound && !pv) r_pfidx <= r_ps_idx;
        end
        if (emit) r_held <= send_res;
        if (emit) r_out <= r_held;
        else if (i_cmd.fin) r_out <= fin_res;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cval    <= '0;
            r_pval    <= '0;
            r_cs_v    <= 1'b0;
            r_ps_v    <= 1'b0;
            r_hit     <= 1'b0;
            r_mfound  <= 1'b0;
            r_ffound  <= 1'b0;
            r_pfound  <= 1'b0;
            r_pffound <= 1'b0;
            r_nemit   <= '0;
            r_held_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_cs_v  <= i_cmd.c_rd;
            r_ps_v  <= i_cmd.p_rd;
            r_out_v <= (emit && r_held_v) || i_cmd.fin;
            if (i_cmd.load) begin
                r_hit     <= 1'b0;
                r_mfound  <= 1'b0;
                r_ffound  <= 1'b0;
                r_pfound  <= 1'b0;
                r_pffound <= 1'b0;
                r_nemit   <= '0;
                r_held_v  <= 1'b0;
            end
            if (r_cs_v) begin
                if (c_match) begin
                    r_hit    <= 1'b1;
                    r_mfound <= 1'b1;
                end
                if (!cv) r_ffound <= 1'b1;
                if (r_req.req_type == OP_TICK && cv && age_exp)
                    r_cval[r_cs_idx] <= 1'b0;
            end
            if (i_cmd.c_wr) r_cval[ins_tgt] <= 1'b1;
            if (r_ps_v) begin
                if (p_match) r_pfound <= 1'b1;
                if (!pv) r_pffound <= 1'b1;
            end
            if (emit) begin
                r_nemit  <= r_nemit + 1'b1;
                r_held_v <= 1'b1;
            end
            if (drop) r_pval[r_ps_idx] <= 1'b0;
            if (i_cmd.p_wr && !r_pfound && r_pffound) r_pval[r_pfidx] <= 1'b1;
            if (i_cmd.fin) begin
                if (r_req.req_type == OP_REMOVE && r_pfound) r_pval[r_pidx] <= 1'b0;
                if (r_req.req_type == OP_CLEAR) begin
                    r_cval <= '0;
                    r_pval <= '0;
                end
            end
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

endmodule

// ----- rtl/arp_cache_with_aging.sv -----
// arp_cache_with_aging: top level, APB register file, controller and datapath.
// Depends on arpc_pkg, arpc_ctrl, arpc_dp.
//
//  channel   signals                          transfer when
//  --------  -------------------------------  ------------------------------
//  request   start, busy, i_req (t_req)       start high while busy low
//  result    o_valid, o_res (t_res)           every cycle o_valid is high
//  config    psel penable pwrite paddr pwdata psel & penable & pwrite (pready=1)
//
// Flow: one request walks the cache (CACHE_DEPTH reads, one per cycle on the
// single cache read port) and/or the request table (REQ_DEPTH reads), plus
// drain, write and finish states. Insert and tick walk both tables, lookup
// only the cache, queue and remove only the request table; clear and unused
// codes go straight to the finish state.
// Reset is synchronous and empties both tables at once.
// Results cannot be stalled; tick send results appear while the table walks.

module arp_cache_with_aging import arpc_pkg::*; #(
    parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
    parameter int REQ_DEPTH   = REQ_DEPTH_DEF,
    localparam int CW = $clog2(CACHE_DEPTH),
    localparam int PW = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_timeout;
    logic [7:0]  r_max_sends;
    logic        wr_en;
    t_cmd          cmd;
    logic [CW-1:0] caddr;
    logic [PW-1:0] paddr_t;

    // registers at byte 0 and 4; other addresses are ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_max_sends <= MAX_SENDS_RST;
        end else if (wr_en) begin
            if (paddr[2] == REG_TIMEOUT) r_timeout   <= pwdata[15:0];
            else                          r_max_sends <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == REG_MAX_SENDS) prdata = {24'd0, r_max_sends};
            else                            prdata = {16'd0, r_timeout};
        end
    end

    arpc_ctrl #(.CACHE_DEPTH(CACHE_DEPTH), .REQ_DEPTH(REQ_DEPTH)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_req.req_type),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .o_caddr (caddr),
        .o_paddr (paddr_t)
    );

    arpc_dp #(.CACHE_DEPTH(CACHE_DEPTH), .REQ_DEPTH(REQ_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_caddr     (caddr),
        .i_paddr     (paddr_t),
        .i_req       (i_req),
        .i_timeout   (r_timeout),
        .i_max_sends (r_max_sends),
        .o_valid     (o_valid),
        .o_res       (o_res)
    );

endmodule
